[hw/rtl/btr_pkg.sv]
// Shared constants, request and result types, and a helper function of the character generator.
package btr_pkg;

  // Font geometry and store organisation.
  localparam int GLYPH_WIDTH  = 8;
  localparam int GLYPH_HEIGHT = 8;
  localparam int NUM_GLYPHS   = 128;
  localparam int MAX_ZOOM     = 8;
  localparam int NUM_BANKS    = 2;

  localparam int GLYPH_IDX_W  = $clog2(NUM_GLYPHS);
  localparam int ROW_W        = $clog2(GLYPH_HEIGHT);
  localparam int BANK_W       = $clog2(NUM_BANKS);
  localparam int STORE_ADDR_W = BANK_W + GLYPH_IDX_W + ROW_W;
  localparam int STORE_DEPTH  = NUM_BANKS * NUM_GLYPHS * GLYPH_HEIGHT;

  // Field widths.
  localparam int COORD_W = 12;
  localparam int ZOOM_W  = 4;
  localparam int INK_W   = 32;
  localparam int MASK_W  = 64;
  localparam int SHIFT_W = $clog2(MASK_W);
  localparam int REP_W   = $clog2(MAX_ZOOM);

  // Depth of the queue between front and back.
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Input request kinds.
  localparam logic [1:0] KIND_DRAW   = 2'd0;
  localparam logic [1:0] KIND_LOAD   = 2'd1;
  localparam logic [1:0] KIND_SETPOS = 2'd2;

  // Control character codes.
  localparam logic [7:0] CODE_CR = 8'd13;
  localparam logic [7:0] CODE_LF = 8'd10;

  // Commands passed from front to back.
  localparam logic [2:0] OP_DRAW   = 3'd0;
  localparam logic [2:0] OP_LOAD   = 3'd1;
  localparam logic [2:0] OP_SETPOS = 3'd2;
  localparam logic [2:0] OP_CR     = 3'd3;
  localparam logic [2:0] OP_LF     = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_ZOOM      = 2'd0;
  localparam logic [1:0] REG_INK_COLOR = 2'd1;
  localparam logic [1:0] REG_FONT_BANK = 2'd2;

  typedef struct packed {
    logic [1:0]             kind;
    logic [7:0]             char_code;
    logic [COORD_W-1:0]     pos_x;
    logic [COORD_W-1:0]     pos_y;
    logic                   load_bank;
    logic [6:0]             load_glyph;
    logic [2:0]             load_row;
    logic [7:0]             load_bits;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] row_x;
    logic [COORD_W-1:0] row_y;
    logic [MASK_W-1:0]  row_pixels;
    logic [INK_W-1:0]   ink;
    logic               last_row;
  } out_item_t;

  typedef struct packed {
    logic [2:0]             op;
    logic [BANK_W-1:0]      bank;
    logic [GLYPH_IDX_W-1:0] glyph;
    logic [ROW_W-1:0]       row;
    logic [7:0]             bits;
    logic [COORD_W-1:0]     pos_x;
    logic [COORD_W-1:0]     pos_y;
  } cmd_t;

  // Settings seen by the back end; zoom is already saturated.
  typedef struct packed {
    logic [ZOOM_W-1:0] zoom;
    logic [INK_W-1:0]  ink;
    logic [BANK_W-1:0] font_bank;
  } cfg_t;

  // Widen a glyph row: each source bit becomes a run of z pixels, bit 0 leftmost.
  function automatic logic [MASK_W-1:0] widen_row(input logic [7:0]        bits,
                                                  input logic [ZOOM_W-1:0] z);
    logic [MASK_W-1:0] m;
    logic [MASK_W-1:0] ones;
    m    = '0;
    ones = (MASK_W'(1) << z) - MASK_W'(1);
    for (int k = 0; k < GLYPH_WIDTH; k++) begin
      if (bits[k]) begin
        m = m | (ones << (SHIFT_W'(k) * SHIFT_W'(z)));
      end
    end
    return m;
  endfunction

endpackage

[hw/rtl/btr_front.sv]
// Front end: accepts input requests, classifies them and hands commands to the queue.
module btr_front
  import btr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output cmd_t     cmd
);

  logic valid_r, valid_nxt;
  cmd_t cmd_r, cmd_nxt;
  logic accept;
  logic keep;

  assign in_ready  = !valid_r || cmd_ready;
  assign accept    = in_valid && in_ready;
  assign cmd_valid = valid_r;
  assign cmd       = cmd_r;

  // Decode the request into a back-end command; an unknown kind is dropped.
  always_comb begin
    cmd_nxt       = cmd_r;
    keep          = 1'b1;
    if (accept) begin
      cmd_nxt.bank  = BANK_W'(in_data.load_bank);
      cmd_nxt.glyph = GLYPH_IDX_W'(in_data.load_glyph);
      cmd_nxt.row   = ROW_W'(in_data.load_row);
      cmd_nxt.bits  = in_data.load_bits;
      cmd_nxt.pos_x = in_data.pos_x;
      cmd_nxt.pos_y = in_data.pos_y;
      cmd_nxt.op    = OP_DRAW;
      case (in_data.kind)
        KIND_DRAW: begin
          if (in_data.char_code == CODE_CR) begin
            cmd_nxt.op = OP_CR;
          end else if (in_data.char_code == CODE_LF) begin
            cmd_nxt.op = OP_LF;
          end else begin
            cmd_nxt.op = OP_DRAW;
            // Codes beyond the font fall back to glyph 0.
            if ({1'b0, in_data.char_code} < 9'(NUM_GLYPHS)) begin
              cmd_nxt.glyph = GLYPH_IDX_W'(in_data.char_code);
            end else begin
              cmd_nxt.glyph = '0;
            end
          end
        end
        KIND_LOAD:   cmd_nxt.op = OP_LOAD;
        KIND_SETPOS: cmd_nxt.op = OP_SETPOS;
        default:     keep = 1'b0;
      endcase
    end
  end

  // Holding register occupancy.
  always_comb begin
    valid_nxt = valid_r;
    if (cmd_ready) begin
      valid_nxt = 1'b0;
    end
    if (accept) begin
      valid_nxt = keep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule

[hw/rtl/btr_fifo.sv]
// Short command queue between the front and back ends.
module btr_fifo
  import btr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_data
);

  cmd_t                  entries_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;
  logic                  push, pop;

  assign push_ready = count_r != FIFO_CNT_W'(FIFO_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = entries_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[hw/rtl/btr_back.sv]
// Back end: glyph store, text cursor and the row sequencer that emits zoomed glyph rows.
module btr_back
  import btr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_t      cmd,
  input  cfg_t      cfg,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [7:0]                         glyph_mem [STORE_DEPTH];
  logic [7:0]                         rd_data_r;
  logic [STORE_ADDR_W-1:0]            rd_addr;

  logic [1:0]                         state_r, state_nxt;
  logic [COORD_W-1:0]                 cursor_x_r, cursor_x_nxt;
  logic [COORD_W-1:0]                 cursor_y_r, cursor_y_nxt;
  logic [BANK_W+GLYPH_IDX_W-1:0]      glyph_r, glyph_nxt;
  logic [ROW_W-1:0]                   gr_r, gr_nxt;
  logic [REP_W-1:0]                   rep_r, rep_nxt;
  logic [COORD_W-1:0]                 y_r, y_nxt;
  logic                               out_valid_r, out_valid_nxt;
  out_item_t                          out_data_r, out_data_nxt;

  logic                               pop;
  logic                               mem_we;
  logic                               out_free;
  logic                               last_rep;
  logic                               last_gr;
  logic [COORD_W-1:0]                 x_step;
  logic [COORD_W-1:0]                 y_step;

  assign cmd_ready = state_r == ST_IDLE;
  assign pop       = cmd_valid && cmd_ready;
  assign mem_we    = pop && (cmd.op == OP_LOAD);
  assign rd_addr   = {glyph_r, gr_r};
  assign out_free  = !out_valid_r || out_ready;
  assign last_rep  = {1'b0, rep_r} == (cfg.zoom - ZOOM_W'(1));
  assign last_gr   = gr_r == ROW_W'(GLYPH_HEIGHT - 1);
  assign x_step    = COORD_W'(cfg.zoom) * COORD_W'(GLYPH_WIDTH);
  assign y_step    = COORD_W'(cfg.zoom) * COORD_W'(GLYPH_HEIGHT);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Glyph store: one write port for loads, registered read for the sequencer.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      glyph_mem[{cmd.bank, cmd.glyph, cmd.row}] <= cmd.bits;
    end
    if (state_r == ST_FETCH) begin
      rd_data_r <= glyph_mem[rd_addr];
    end
  end

  // Command execution and row sequencing.
  always_comb begin
    state_nxt     = state_r;
    cursor_x_nxt  = cursor_x_r;
    cursor_y_nxt  = cursor_y_r;
    glyph_nxt     = glyph_r;
    gr_nxt        = gr_r;
    rep_nxt       = rep_r;
    y_nxt         = y_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          case (cmd.op)
            OP_SETPOS: begin
              cursor_x_nxt = cmd.pos_x;
              cursor_y_nxt = cmd.pos_y;
            end
            OP_CR: cursor_x_nxt = '0;
            OP_LF: begin
              cursor_x_nxt = '0;
              cursor_y_nxt = cursor_y_r + y_step;
            end
            OP_DRAW: begin
              // A zero zoom draws nothing and leaves the cursor alone.
              if (cfg.zoom != '0) begin
                glyph_nxt = {cfg.font_bank, cmd.glyph};
                gr_nxt    = '0;
                rep_nxt   = '0;
                y_nxt     = cursor_y_r + COORD_W'(1);
                state_nxt = ST_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.row_x      = cursor_x_r;
          out_data_nxt.row_y      = y_r;
          out_data_nxt.row_pixels = widen_row(rd_data_r, cfg.zoom);
          out_data_nxt.ink        = cfg.ink;
          out_data_nxt.last_row   = last_rep && last_gr;
          y_nxt                   = y_r + COORD_W'(1);
          if (last_rep) begin
            rep_nxt = '0;
            if (last_gr) begin
              cursor_x_nxt = cursor_x_r + x_step;
              state_nxt    = ST_IDLE;
            end else begin
              gr_nxt    = gr_r + 1'b1;
              state_nxt = ST_FETCH;
            end
          end else begin
            rep_nxt = rep_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cursor_x_r  <= '0;
      cursor_y_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_x_r  <= cursor_x_nxt;
      cursor_y_r  <= cursor_y_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    glyph_r    <= glyph_nxt;
    gr_r       <= gr_nxt;
    rep_r      <= rep_nxt;
    y_r        <= y_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

[hw/rtl/bitmap_text_renderer_unit.sv]
// Top level of the bitmap character generator: configuration registers and the front/back pipeline.
//
// Requests load glyph row bytes, set the text cursor or draw a character. A drawn character
// produces GLYPH_HEIGHT*zoom row results (64 at zoom 8); each glyph row is first read from the
// glyph store in the fetch state and then sent zoom times from the emit state, which waits
// while the previous result has not been taken. Loads, cursor moves and carriage return or
// line feed are carried out by the back end while it is idle. A two-entry queue lets requests
// be accepted while a character is still being drawn. The glyph store has no reset; draw only
// glyphs that have been loaded. Zoom values above 8 act as 8; zoom 0 draws nothing.
module bitmap_text_renderer_unit
  import btr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [ZOOM_W-1:0] zoom_r;
  logic [INK_W-1:0]  ink_r;
  logic [BANK_W-1:0] font_bank_r;
  logic              cfg_write;
  logic [1:0]        reg_idx;
  cfg_t              cfg;

  logic              q_push_valid, q_push_ready;
  cmd_t              q_push_data;
  logic              q_pop_valid, q_pop_ready;
  cmd_t              q_pop_data;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = paddr[3:2];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zoom_r      <= ZOOM_W'(1);
      ink_r       <= INK_W'(32'h00FF_FFFF);
      font_bank_r <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_ZOOM:      zoom_r      <= pwdata[ZOOM_W-1:0];
        REG_INK_COLOR: ink_r       <= pwdata[INK_W-1:0];
        REG_FONT_BANK: font_bank_r <= pwdata[BANK_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      REG_ZOOM:      prdata = 32'(zoom_r);
      REG_INK_COLOR: prdata = ink_r;
      REG_FONT_BANK: prdata = 32'(font_bank_r);
      default:       prdata = '0;
    endcase
  end

  // Settings for the back end, with zoom saturated to the largest supported factor.
  always_comb begin
    cfg.zoom      = (zoom_r > ZOOM_W'(MAX_ZOOM)) ? ZOOM_W'(MAX_ZOOM) : zoom_r;
    cfg.ink       = ink_r;
    cfg.font_bank = font_bank_r;
  end

  btr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (q_push_valid),
    .cmd_ready (q_push_ready),
    .cmd       (q_push_data)
  );

  btr_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  btr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_pop_valid),
    .cmd_ready (q_pop_ready),
    .cmd       (q_pop_data),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
